>>> hdl/eop_pkg.sv
package eop_pkg;

   localparam int TRIG_W      = 32;
   localparam int DEG_W       = 9;
   localparam int AXIS_W      = 11;
   localparam int COORD_W     = 16;
   localparam int RADIUS_W    = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int TAB_LAST    = 90;

   localparam logic [DEG_W-1:0] DEG_QUARTER = 9'd90;
   localparam logic [DEG_W-1:0] DEG_HALF    = 9'd180;
   localparam logic [DEG_W-1:0] DEG_3QUART  = 9'd270;
   localparam logic [DEG_W-1:0] DEG_TURN    = 9'd360;

   localparam logic [CSR_IDX_W-1:0] CSR_SEMI_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEMI_B   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd4;

   localparam logic [63:0] Q30_ONE  = 64'd1073741824;
   localparam logic [63:0] PI_Q30   = 64'd3373259426;
   localparam logic [63:0] Q30_HALF = 64'd536870912;

   typedef logic [TRIG_W-1:0] trig_tab_type [0:TAB_LAST];

   typedef struct packed {
      logic signed [TRIG_W-1:0] s;
      logic signed [TRIG_W-1:0] c;
   } trig_pair_type;

   function automatic logic [63:0] q_mul(input logic [63:0] p, input logic [63:0] q);
      return (p * q + Q30_HALF) >> 30;
   endfunction

   // Sine (or cosine when want_cos is set) of 0..90 whole degrees in Q30, built
   // from the octant series. At 45 degrees each table keeps its own series.
   function automatic trig_tab_type build_trig_tab(input bit want_cos);
      trig_tab_type tab;
      logic [63:0]  dd;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      for (int d = 0; d <= TAB_LAST; d++) begin
         dd = (d <= 45) ? 64'(d) : 64'(TAB_LAST - d);
         x  = (dd * PI_Q30 + 64'd90) / 64'd180;
         x2 = q_mul(x, x);
         t  = Q30_ONE - x2 / 64'd72;
         t  = Q30_ONE - q_mul(x2, t) / 64'd42;
         t  = Q30_ONE - q_mul(x2, t) / 64'd20;
         t  = Q30_ONE - q_mul(x2, t) / 64'd6;
         s  = q_mul(x, t);
         t  = Q30_ONE - x2 / 64'd90;
         t  = Q30_ONE - q_mul(x2, t) / 64'd56;
         t  = Q30_ONE - q_mul(x2, t) / 64'd30;
         t  = Q30_ONE - q_mul(x2, t) / 64'd12;
         t  = Q30_ONE - q_mul(x2, t) / 64'd2;
         tab[d] = ((d <= 45) != want_cos) ? s[TRIG_W-1:0] : t[TRIG_W-1:0];
      end
      return tab;
   endfunction

   localparam trig_tab_type SIN_TAB = build_trig_tab(1'b0);
   localparam trig_tab_type COS_TAB = build_trig_tab(1'b1);

   // Signed Q30 sine and cosine of deg in 0..359.
   function automatic trig_pair_type deg_trig(input logic [DEG_W-1:0] deg);
      trig_pair_type     res;
      logic [DEG_W-1:0]  r;
      logic [1:0]        q;
      logic signed [TRIG_W-1:0] sv;
      logic signed [TRIG_W-1:0] cv;
      if (deg < DEG_QUARTER) begin
         q = 2'd0; r = deg;
      end else if (deg < DEG_HALF) begin
         q = 2'd1; r = deg - DEG_QUARTER;
      end else if (deg < DEG_3QUART) begin
         q = 2'd2; r = deg - DEG_HALF;
      end else begin
         q = 2'd3; r = deg - DEG_3QUART;
      end
      sv = $signed(SIN_TAB[r[6:0]]);
      cv = $signed(COS_TAB[r[6:0]]);
      unique case (q)
         2'd0: begin res.s = sv;  res.c = cv;  end
         2'd1: begin res.s = cv;  res.c = -sv; end
         2'd2: begin res.s = -sv; res.c = -cv; end
         default: begin res.s = -cv; res.c = sv; end
      endcase
      return res;
   endfunction

endpackage

>>> hdl/ellipse_outline_point.sv
// Ellipse outline point: for each request angle t (whole degrees, taken modulo 360)
// the block returns the polar radius r = ab / sqrt(b^2 cos^2 t + a^2 sin^2 t) in
// unsigned Q12.4 (saturated to 32767) and the point center + r*(cos(t+phi),
// sin(t+phi)) in signed Q12.4, saturated, with phi the configured rotation.
// A zero semi-axis gives r = 0 and the point at the center. One item enters per
// clock and one result leaves per clock while no untaken result at the output stalls
// the pipe; each item passes the 28-stage square root and the one-bit-per-stage
// divider. Sine and cosine come from 91-entry quarter-wave tables. Write the
// CSRs only while no item is in flight.
module ellipse_outline_point import eop_pkg::*; #(
   parameter int FRAC_BITS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [DEG_W-1:0]           req_angle_deg,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [COORD_W-1:0]  rsp_point_x,
   output logic signed [COORD_W-1:0]  rsp_point_y,
   output logic [RADIUS_W-1:0]        rsp_radius,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AB_W   = 2 * AXIS_W;
   localparam int SQ_W   = 34;
   localparam int D_W    = 56;
   localparam int ROOT_W = D_W / 2;
   localparam int Q_W    = 12 + FRAC_BITS;
   localparam int N_W    = AB_W + 17 + FRAC_BITS;
   localparam int P_W    = Q_W + 1 + TRIG_W;
   localparam int SH_W   = P_W - 30;
   localparam int SUM_W  = ((SH_W > COORD_W) ? SH_W : COORD_W) + 1;
   localparam int RX_W   = (Q_W > RADIUS_W) ? Q_W : RADIUS_W + 1;
   localparam int SQ_SIDE_W  = 2 * TRIG_W + AB_W + 1;
   localparam int DIV_SIDE_W = 2 * TRIG_W + 1;

   // CSRs
   logic [AXIS_W-1:0]         semi_a_ff;
   logic [AXIS_W-1:0]         semi_b_ff;
   logic [DEG_W-1:0]          rot_ff;
   logic signed [COORD_W-1:0] cx_ff;
   logic signed [COORD_W-1:0] cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         semi_a_ff <= AXIS_W'(1);
         semi_b_ff <= AXIS_W'(1);
         rot_ff    <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEMI_A:   semi_a_ff <= csr_wdata[AXIS_W-1:0];
            CSR_SEMI_B:   semi_b_ff <= csr_wdata[AXIS_W-1:0];
            CSR_ROTATION: rot_ff    <= csr_wdata[DEG_W-1:0];
            CSR_CENTER_X: cx_ff     <= $signed(csr_wdata);
            CSR_CENTER_Y: cy_ff     <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Global advance: the whole pipe moves unless the output holds an untaken item.
   // Take no item while reset is held.
   logic en;
   logic vo_ff;
   assign en        = ~vo_ff | rsp_ready;
   assign req_ready = en & ~reset;

   // Stage 1: reduce angles modulo a turn.
   logic [DEG_W-1:0] ang_mod;
   logic [DEG_W-1:0] rot_mod;
   logic [DEG_W:0]   tp_sum;
   logic [DEG_W:0]   tp_mod;
   assign ang_mod = (req_angle_deg >= DEG_TURN) ? req_angle_deg - DEG_TURN : req_angle_deg;
   assign rot_mod = (rot_ff >= DEG_TURN) ? rot_ff - DEG_TURN : rot_ff;
   assign tp_sum  = {1'b0, ang_mod} + {1'b0, rot_mod};
   assign tp_mod  = (tp_sum >= {1'b0, DEG_TURN}) ? tp_sum - {1'b0, DEG_TURN} : tp_sum;

   logic             v1_ff;
   logic [DEG_W-1:0] t1_ff;
   logic [DEG_W-1:0] tp1_ff;

   // Stage 2: table lookups and axis products.
   logic          v2_ff;
   trig_pair_type tt2_ff;
   trig_pair_type tp2_ff;
   logic [AB_W-1:0] aa2_ff, bb2_ff, ab2_ff;
   logic          z2_ff;

   // Stage 3: round to Q16 magnitudes and square.
   logic [TRIG_W-1:0] cmag;
   logic [TRIG_W-1:0] smag;
   logic [16:0]       cq;
   logic [16:0]       sq;
   assign cmag = tt2_ff.c[TRIG_W-1] ? TRIG_W'(-tt2_ff.c) : tt2_ff.c;
   assign smag = tt2_ff.s[TRIG_W-1] ? TRIG_W'(-tt2_ff.s) : tt2_ff.s;
   assign cq   = 17'((cmag + TRIG_W'(32'h2000)) >> 14);
   assign sq   = 17'((smag + TRIG_W'(32'h2000)) >> 14);

   logic            v3_ff;
   logic [SQ_W-1:0] cc3_ff, ss3_ff;
   logic [AB_W-1:0] aa3_ff, bb3_ff, ab3_ff;
   logic            z3_ff;
   trig_pair_type   tp3_ff;

   // Stage 4: weight the squares by the axes.
   logic            v4_ff;
   logic [D_W-1:0]  p14_ff, p24_ff;
   logic [AB_W-1:0] ab4_ff;
   logic            z4_ff;
   trig_pair_type   tp4_ff;

   // Stage 5: sum into the radicand.
   logic            v5_ff;
   logic [D_W-1:0]  d5_ff;
   logic [AB_W-1:0] ab5_ff;
   logic            z5_ff;
   trig_pair_type   tp5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff  <= ang_mod;
         tp1_ff <= tp_mod[DEG_W-1:0];

         tt2_ff <= deg_trig(t1_ff);
         tp2_ff <= deg_trig(tp1_ff);
         aa2_ff <= AB_W'(semi_a_ff) * AB_W'(semi_a_ff);
         bb2_ff <= AB_W'(semi_b_ff) * AB_W'(semi_b_ff);
         ab2_ff <= AB_W'(semi_a_ff) * AB_W'(semi_b_ff);
         z2_ff  <= (semi_a_ff == '0) || (semi_b_ff == '0);

         cc3_ff <= SQ_W'(cq) * SQ_W'(cq);
         ss3_ff <= SQ_W'(sq) * SQ_W'(sq);
         aa3_ff <= aa2_ff;
         bb3_ff <= bb2_ff;
         ab3_ff <= ab2_ff;
         z3_ff  <= z2_ff;
         tp3_ff <= tp2_ff;

         p14_ff <= D_W'(bb3_ff) * D_W'(cc3_ff);
         p24_ff <= D_W'(aa3_ff) * D_W'(ss3_ff);
         ab4_ff <= ab3_ff;
         z4_ff  <= z3_ff;
         tp4_ff <= tp3_ff;

         d5_ff  <= p14_ff + p24_ff;
         ab5_ff <= ab4_ff;
         z5_ff  <= z4_ff;
         tp5_ff <= tp4_ff;
      end
   end

   // Square root of the radicand.
   logic                 sq_v;
   logic [ROOT_W-1:0]    sq_root;
   logic [SQ_SIDE_W-1:0] sq_side;

   eop_isqrt #(
      .D_W    (D_W),
      .SIDE_W (SQ_SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_d      (d5_ff),
      .in_side   ({tp5_ff, ab5_ff, z5_ff}),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Rounded quotient: (ab << (16+FRAC_BITS) + S/2) / S.
   trig_pair_type   sq_tp;
   logic [AB_W-1:0] sq_ab;
   logic            sq_z;
   logic [N_W-1:0]  div_num;
   logic            div_zero;
   assign {sq_tp, sq_ab, sq_z} = sq_side;
   assign div_num  = {1'b0, sq_ab, {(16 + FRAC_BITS){1'b0}}} + N_W'(sq_root >> 1);
   assign div_zero = sq_z || (sq_root == '0);

   logic                  dv_v;
   logic [Q_W-1:0]        dv_quo;
   logic [DIV_SIDE_W-1:0] dv_side;

   eop_rdiv #(
      .N_W    (N_W),
      .DEN_W  (ROOT_W),
      .Q_W    (Q_W),
      .SIDE_W (DIV_SIDE_W)
   ) u_rdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_v),
      .in_num    (div_num),
      .in_den    (sq_root),
      .in_side   ({sq_tp, div_zero}),
      .out_valid (dv_v),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   trig_pair_type  dv_tp;
   logic           dv_z;
   logic [Q_W-1:0] r_val;
   assign {dv_tp, dv_z} = dv_side;
   assign r_val = dv_z ? '0 : dv_quo;

   // Multiply stage: radius times rotated cosine and sine.
   logic                  vm_ff;
   logic signed [P_W-1:0] mx_ff, my_ff;
   logic [Q_W-1:0]        rm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (en) begin
         vm_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff <= P_W'($signed({1'b0, r_val}) * dv_tp.c);
         my_ff <= P_W'($signed({1'b0, r_val}) * dv_tp.s);
         rm_ff <= r_val;
      end
   end

   // Output stage: round half up out of Q30, add the center, saturate.
   localparam logic signed [P_W-1:0]   HALF_P = P_W'(Q30_HALF);
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

   logic signed [P_W-1:0]   wx, wy;
   logic signed [SH_W-1:0]  ox, oy;
   logic signed [SUM_W-1:0] sx, sy;
   logic signed [COORD_W-1:0] px_in, py_in;
   logic [RX_W-1:0]         rx;
   logic [RADIUS_W-1:0]     rad_in;

   assign wx = mx_ff + HALF_P;
   assign wy = my_ff + HALF_P;
   assign ox = wx[P_W-1:30];
   assign oy = wy[P_W-1:30];
   assign sx = SUM_W'(cx_ff) + SUM_W'(ox);
   assign sy = SUM_W'(cy_ff) + SUM_W'(oy);

   always_comb begin
      priority if (sx > SAT_HI) px_in = 16'sh7fff;
      else if (sx < SAT_LO)     px_in = -16'sh8000;
      else                      px_in = sx[COORD_W-1:0];
      priority if (sy > SAT_HI) py_in = 16'sh7fff;
      else if (sy < SAT_LO)     py_in = -16'sh8000;
      else                      py_in = sy[COORD_W-1:0];
   end

   assign rx     = RX_W'(rm_ff);
   assign rad_in = (rx > RX_W'(32767)) ? 15'h7fff : rx[RADIUS_W-1:0];

   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic [RADIUS_W-1:0]       rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         rad_ff <= rad_in;
      end
   end

   assign rsp_valid   = vo_ff;
   assign rsp_point_x = px_ff;
   assign rsp_point_y = py_ff;
   assign rsp_radius  = rad_ff;

endmodule

>>> hdl/eop_isqrt.sv
module eop_isqrt import eop_pkg::*; #(
   parameter int D_W    = 56,
   parameter int SIDE_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [D_W-1:0]       in_d,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [D_W/2-1:0]     out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int R_W = D_W / 2;

   logic              v_ff    [1:R_W];
   logic [R_W+1:0]    rem_ff  [1:R_W];
   logic [R_W-1:0]    root_ff [1:R_W];
   logic [D_W-1:0]    dsh_ff  [1:R_W];
   logic [SIDE_W-1:0] side_ff [1:R_W];

   // One result bit per stage, two radicand bits consumed per stage.
   for (genvar k = 1; k <= R_W; k++) begin : g_stage
      logic              v_pre;
      logic [R_W+1:0]    rem_pre;
      logic [R_W-1:0]    root_pre;
      logic [D_W-1:0]    dsh_pre;
      logic [SIDE_W-1:0] side_pre;
      logic [R_W+1:0]    rem_sh;
      logic [R_W+1:0]    trial;

      if (k == 1) begin : g_first
         assign v_pre    = in_valid;
         assign rem_pre  = '0;
         assign root_pre = '0;
         assign dsh_pre  = in_d;
         assign side_pre = in_side;
      end else begin : g_next
         assign v_pre    = v_ff[k-1];
         assign rem_pre  = rem_ff[k-1];
         assign root_pre = root_ff[k-1];
         assign dsh_pre  = dsh_ff[k-1];
         assign side_pre = side_ff[k-1];
      end

      assign rem_sh = {rem_pre[R_W-1:0], dsh_pre[D_W-1:D_W-2]};
      assign trial  = {root_pre, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_pre;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dsh_ff[k]  <= dsh_pre << 2;
            side_ff[k] <= side_pre;
            if (rem_sh >= trial) begin
               rem_ff[k]  <= rem_sh - trial;
               root_ff[k] <= {root_pre[R_W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= rem_sh;
               root_ff[k] <= {root_pre[R_W-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = v_ff[R_W];
   assign out_root  = root_ff[R_W];
   assign out_side  = side_ff[R_W];

endmodule

>>> hdl/eop_rdiv.sv
module eop_rdiv import eop_pkg::*; #(
   parameter int N_W    = 43,
   parameter int DEN_W  = 28,
   parameter int Q_W    = 16,
   parameter int SIDE_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [N_W-1:0]       in_num,
   input  logic [DEN_W-1:0]     in_den,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [Q_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int C_W = (DEN_W + Q_W > N_W) ? DEN_W + Q_W : N_W;

   logic              v_ff    [1:Q_W];
   logic [C_W-1:0]    rem_ff  [1:Q_W];
   logic [DEN_W-1:0]  den_ff  [1:Q_W];
   logic [Q_W-1:0]    quo_ff  [1:Q_W];
   logic [SIDE_W-1:0] side_ff [1:Q_W];

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar k = 1; k <= Q_W; k++) begin : g_stage
      logic              v_pre;
      logic [C_W-1:0]    rem_pre;
      logic [DEN_W-1:0]  den_pre;
      logic [Q_W-1:0]    quo_pre;
      logic [SIDE_W-1:0] side_pre;
      logic [C_W-1:0]    den_sh;

      if (k == 1) begin : g_first
         assign v_pre    = in_valid;
         assign rem_pre  = C_W'(in_num);
         assign den_pre  = in_den;
         assign quo_pre  = '0;
         assign side_pre = in_side;
      end else begin : g_next
         assign v_pre    = v_ff[k-1];
         assign rem_pre  = rem_ff[k-1];
         assign den_pre  = den_ff[k-1];
         assign quo_pre  = quo_ff[k-1];
         assign side_pre = side_ff[k-1];
      end

      assign den_sh = C_W'(den_pre) << (Q_W - k);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_pre;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k]  <= den_pre;
            side_ff[k] <= side_pre;
            if (rem_pre >= den_sh) begin
               rem_ff[k] <= rem_pre - den_sh;
               quo_ff[k] <= quo_pre | (Q_W'(1) << (Q_W - k));
            end else begin
               rem_ff[k] <= rem_pre;
               quo_ff[k] <= quo_pre;
            end
         end
      end
   end

   assign out_valid = v_ff[Q_W];
   assign out_quo   = quo_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule
